// ----- src/ppp_pkg.sv -----
// Shared types and constants of the perspective point projection block.
`timescale 1ns / 1ps

package ppp_pkg;

   localparam int DATA_W             = 32;
   localparam int SIZE_W             = 14;
   localparam int INDEX_W            = 5;
   localparam int STATUS_W           = 2;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 14;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int CLAMP_SHIFT        = 33;
   localparam int CLAMP_W            = CLAMP_SHIFT + 2;
   localparam int PIX_W              = CLAMP_W + SIZE_W + 1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_VISIBLE   = 2'd0,
      STATUS_BAD_SIZE  = 2'd1,
      STATUS_W_INVALID = 2'd2,
      STATUS_DEPTH     = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SURFACE_WIDTH  = 2'd0,
      CSR_SURFACE_HEIGHT = 2'd1,
      CSR_SOURCE_ENABLE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       valid;
      logic       point;
      logic       world_ovf;
      status_type status;
   } sideband_type;

endpackage

// ----- src/ppp_if.sv -----
// Request and response channel interfaces of the projection block.
`timescale 1ns / 1ps

interface ppp_req_if import ppp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [INDEX_W-1:0]        coef_index;
   logic signed [DATA_W-1:0]  coef_value;
   logic signed [DATA_W-1:0]  point_x;
   logic signed [DATA_W-1:0]  point_y;
   logic signed [DATA_W-1:0]  point_z;

   modport source (output valid, kind, coef_index, coef_value, point_x, point_y, point_z,
                   input ready);
   modport sink (input valid, kind, coef_index, coef_value, point_x, point_y, point_z,
                 output ready);
endinterface

interface ppp_rsp_if import ppp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [DATA_W-1:0]  view_x;
   logic signed [DATA_W-1:0]  view_y;

   modport source (output valid, status, view_x, view_y, input ready);
   modport sink (input valid, status, view_x, view_y, output ready);
endinterface

// ----- src/ppp_mat_stage.sv -----
// Matrix store and two-stage matrix-vector multiply with overflow detection.
`timescale 1ns / 1ps

module ppp_mat_stage import ppp_pkg::*; #(
   parameter int ROWS      = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     wr_enable,
   input  logic [3:0]               wr_index,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     bypass,
   input  logic signed [DATA_W-1:0] vec_in [3],
   output logic signed [DATA_W-1:0] vec_out [ROWS],
   output logic                     overflow
);

   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

   logic signed [DATA_W-1:0] coef_ff [16];
   logic signed [PROD_W-1:0] prod_in [ROWS][3];
   logic signed [PROD_W-1:0] prod_ff [ROWS][3];
   logic signed [DATA_W-1:0] trans_ff [ROWS];
   logic signed [DATA_W-1:0] vec_ff [3];
   logic                     pass_ff;
   logic signed [DATA_W-1:0] out_in [ROWS];
   logic signed [DATA_W-1:0] out_ff [ROWS];
   logic                     ovf_in;
   logic                     ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            coef_ff[i] <= ((i / 4) == (i % 4)) ? ONE_FX : '0;
         end
      end else if (wr_enable) begin
         coef_ff[wr_index] <= wr_data;
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] p;
      p = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < 3; c++) begin
            p = coef_ff[c*4+r] * vec_in[c];
            prod_in[r][c] = p >>> FRAC_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         vec_ff  <= vec_in;
         pass_ff <= bypass;
         for (int r = 0; r < ROWS; r++) begin
            trans_ff[r] <= coef_ff[12+r];
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] s;
      s = '0;
      ovf_in = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         s = SUM_W'(trans_ff[r]) + SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
             + SUM_W'(prod_ff[r][2]);
         if (pass_ff && r < 3) begin
            out_in[r] = vec_ff[(r < 3) ? r : 0];
         end else begin
            out_in[r] = s[DATA_W-1:0];
            if (s != SUM_W'(signed'(s[DATA_W-1:0]))) begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
         ovf_ff <= ovf_in;
      end
   end

   assign vec_out  = out_ff;
   assign overflow = ovf_ff;

endmodule

// ----- src/ppp_div.sv -----
// Pipelined signed restoring divider, truncating toward zero.
`timescale 1ns / 1ps

module ppp_div import ppp_pkg::*; #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic signed [DEN_W-1:0] divisor,
   output logic signed [NUM_W:0]   quotient
);

   localparam int STEPS = (NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

   logic [NUM_W-1:0] num_ff [STEPS+1];
   logic [DEN_W:0]   rem_ff [STEPS];
   logic [DEN_W-1:0] den_ff [STEPS];
   logic             neg_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         den_ff[0] <= divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
         rem_ff[0] <= '0;
         neg_ff[0] <= dividend[NUM_W-1] ^ divisor[DEN_W-1];
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [NUM_W-1:0] num_in;
      logic [DEN_W:0]   rem_in;

      always_comb begin
         logic [DEN_W:0] t;
         t      = '0;
         num_in = num_ff[s];
         rem_in = rem_ff[s];
         for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            if (s * DIV_BITS_PER_STAGE + k < NUM_W) begin
               t      = {rem_in[DEN_W-1:0], num_in[NUM_W-1]};
               num_in = {num_in[NUM_W-2:0], 1'b0};
               if (t >= {1'b0, den_ff[s]}) begin
                  t         = t - {1'b0, den_ff[s]};
                  num_in[0] = 1'b1;
               end
               rem_in = t;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s+1] <= num_in;
            neg_ff[s+1] <= neg_ff[s];
         end
      end

      if (s + 1 < STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s+1] <= rem_in;
               den_ff[s+1] <= den_ff[s];
            end
         end
      end
   end

   assign quotient = neg_ff[STEPS] ? -signed'({1'b0, num_ff[STEPS]})
                                   : signed'({1'b0, num_ff[STEPS]});

endmodule

// ----- src/ppp_view.sv -----
// Viewport offset, clamp and scale by surface size, two register stages.
`timescale 1ns / 1ps

module ppp_view import ppp_pkg::*; #(
   parameter int NUM_W     = 48,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [NUM_W:0]   ndc_x,
   input  logic signed [NUM_W:0]   ndc_y,
   input  logic [SIZE_W-1:0]       width,
   input  logic [SIZE_W-1:0]       height,
   output logic signed [PIX_W-1:0] scaled_x,
   output logic signed [PIX_W-1:0] scaled_y
);

   localparam int T_W = NUM_W + 2;
   localparam logic signed [T_W-1:0] ONE_FX = T_W'(1) <<< FRAC_BITS;
   localparam logic signed [T_W-1:0] CLAMP  = T_W'(1) <<< CLAMP_SHIFT;

   logic signed [T_W-1:0]     tx;
   logic signed [T_W-1:0]     ty;
   logic signed [CLAMP_W-1:0] cx_ff;
   logic signed [CLAMP_W-1:0] cy_ff;
   logic signed [PIX_W-1:0]   sx_ff;
   logic signed [PIX_W-1:0]   sy_ff;

   function automatic logic signed [CLAMP_W-1:0] clamp(input logic signed [T_W-1:0] v);
      logic signed [T_W-1:0] c;
      c = (v > CLAMP) ? CLAMP : ((v < -CLAMP) ? -CLAMP : v);
      return c[CLAMP_W-1:0];
   endfunction

   assign tx = T_W'(ndc_x) + ONE_FX;
   assign ty = ONE_FX - T_W'(ndc_y);

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff <= clamp(tx);
         cy_ff <= clamp(ty);
         sx_ff <= cx_ff * signed'({1'b0, width});
         sy_ff <= cy_ff * signed'({1'b0, height});
      end
   end

   assign scaled_x = sx_ff;
   assign scaled_y = sy_ff;

endmodule

// ----- src/perspective_point_projection.sv -----
// Top level of the perspective point projection pipeline.
`timescale 1ns / 1ps

// Takes one transaction per cycle while the response channel does not stall: coefficient writes (kind 0) and point
// projections (kind 1) flow through the same pipeline in order, and each point yields
// one response after passing through the pipelined divider, which resolves four
// quotient bits per stage. A coefficient write takes effect for every point accepted
// after it. Configuration registers must be written while the pipeline is empty.
module perspective_point_projection import ppp_pkg::*; #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   ppp_req_if.sink                req_if,
   ppp_rsp_if.source              rsp_if
);

   localparam int CUT_W     = (COEF_WIDTH > DATA_W) ? DATA_W : COEF_WIDTH;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DIV_STEPS = (DIV_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int LAST      = 8 + DIV_STEPS;
   localparam int W_TINY    = int'((64'd1 << FRAC_BITS) / 1000000);

   logic [SIZE_W-1:0]        surface_width_ff;
   logic [SIZE_W-1:0]        surface_height_ff;
   logic                     source_enable_ff;

   sideband_type             sb_ff [LAST+1];
   logic [INDEX_W-1:0]       idx_ff [3];
   logic signed [DATA_W-1:0] val_ff [3];
   logic signed [DATA_W-1:0] point_ff [3];
   logic signed [CUT_W-1:0]  coef_cut;
   logic                     advance;

   logic signed [DATA_W-1:0] world [3];
   logic                     world_ovf;
   logic signed [DATA_W-1:0] clip [4];
   logic                     clip_ovf;
   logic                     src_wr;
   logic                     vp_wr;

   logic signed [DATA_W:0]   w_ext;
   logic signed [DATA_W:0]   z_ext;
   logic [DATA_W:0]          aw;
   logic [DATA_W:0]          az;
   status_type               status_in;

   logic signed [DIV_W:0]    ndc_x;
   logic signed [DIV_W:0]    ndc_y;
   logic signed [PIX_W-1:0]  scaled_x;
   logic signed [PIX_W-1:0]  scaled_y;
   logic signed [PIX_W-1:0]  half_x;
   logic signed [PIX_W-1:0]  half_y;
   logic signed [DATA_W-1:0] view_x_in;
   logic signed [DATA_W-1:0] view_y_in;
   logic signed [DATA_W-1:0] view_x_ff;
   logic signed [DATA_W-1:0] view_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_width_ff  <= '0;
         surface_height_ff <= '0;
         source_enable_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SURFACE_WIDTH:  surface_width_ff  <= csr_write_data;
            CSR_SURFACE_HEIGHT: surface_height_ff <= csr_write_data;
            CSR_SOURCE_ENABLE:  source_enable_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;
   assign coef_cut     = req_if.coef_value[CUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            sb_ff[k] <= '0;
         end
      end else if (advance) begin
         sb_ff[0] <= '{valid: req_if.valid, point: req_if.kind, world_ovf: 1'b0,
                      status: STATUS_VISIBLE};
         for (int k = 1; k <= LAST; k++) begin
            if (k == 3) begin
               sb_ff[k] <= '{valid: sb_ff[k-1].valid, point: sb_ff[k-1].point,
                             world_ovf: world_ovf, status: sb_ff[k-1].status};
            end else if (k == 5) begin
               sb_ff[k] <= '{valid: sb_ff[k-1].valid, point: sb_ff[k-1].point,
                             world_ovf: sb_ff[k-1].world_ovf, status: status_in};
            end else begin
               sb_ff[k] <= sb_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff[0]   <= req_if.coef_index;
         val_ff[0]   <= DATA_W'(coef_cut);
         point_ff[0] <= req_if.point_x;
         point_ff[1] <= req_if.point_y;
         point_ff[2] <= req_if.point_z;
         idx_ff[1]   <= idx_ff[0];
         val_ff[1]   <= val_ff[0];
         idx_ff[2]   <= idx_ff[1];
         val_ff[2]   <= val_ff[1];
      end
   end

   assign src_wr = advance && sb_ff[0].valid && !sb_ff[0].point && idx_ff[0][INDEX_W-1];
   assign vp_wr  = advance && sb_ff[2].valid && !sb_ff[2].point && !idx_ff[2][INDEX_W-1];

   ppp_mat_stage #(.ROWS(3), .FRAC_BITS(FRAC_BITS)) u_src (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .wr_enable (src_wr),
      .wr_index  (idx_ff[0][3:0]),
      .wr_data   (val_ff[0]),
      .bypass    (!source_enable_ff),
      .vec_in    (point_ff),
      .vec_out   (world),
      .overflow  (world_ovf)
   );

   ppp_mat_stage #(.ROWS(4), .FRAC_BITS(FRAC_BITS)) u_vp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .wr_enable (vp_wr),
      .wr_index  (idx_ff[2][3:0]),
      .wr_data   (val_ff[2]),
      .bypass    (1'b0),
      .vec_in    (world),
      .vec_out   (clip),
      .overflow  (clip_ovf)
   );

   assign w_ext = (DATA_W+1)'(clip[3]);
   assign z_ext = (DATA_W+1)'(clip[2]);
   assign aw    = w_ext[DATA_W] ? unsigned'(-w_ext) : unsigned'(w_ext);
   assign az    = z_ext[DATA_W] ? unsigned'(-z_ext) : unsigned'(z_ext);

   always_comb begin
      if (surface_width_ff == '0 || surface_height_ff == '0) begin
         status_in = STATUS_BAD_SIZE;
      end else if (sb_ff[4].world_ovf || clip_ovf || aw <= (DATA_W+1)'(W_TINY)) begin
         status_in = STATUS_W_INVALID;
      end else if (az > aw) begin
         status_in = STATUS_DEPTH;
      end else begin
         status_in = STATUS_VISIBLE;
      end
   end

   ppp_div #(.NUM_W(DIV_W), .DEN_W(DATA_W)) u_div_x (
      .clock    (clock),
      .advance  (advance),
      .dividend ({clip[0], FRAC_BITS'(0)}),
      .divisor  (clip[3]),
      .quotient (ndc_x)
   );

   ppp_div #(.NUM_W(DIV_W), .DEN_W(DATA_W)) u_div_y (
      .clock    (clock),
      .advance  (advance),
      .dividend ({clip[1], FRAC_BITS'(0)}),
      .divisor  (clip[3]),
      .quotient (ndc_y)
   );

   ppp_view #(.NUM_W(DIV_W), .FRAC_BITS(FRAC_BITS)) u_view (
      .clock    (clock),
      .advance  (advance),
      .ndc_x    (ndc_x),
      .ndc_y    (ndc_y),
      .width    (surface_width_ff),
      .height   (surface_height_ff),
      .scaled_x (scaled_x),
      .scaled_y (scaled_y)
   );

   assign half_x = scaled_x >>> 1;
   assign half_y = scaled_y >>> 1;

   always_comb begin
      if (sb_ff[LAST-1].status != STATUS_VISIBLE) begin
         view_x_in = '0;
         view_y_in = '0;
      end else begin
         if (half_x != PIX_W'(signed'(half_x[DATA_W-1:0]))) begin
            view_x_in = half_x[PIX_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            view_x_in = half_x[DATA_W-1:0];
         end
         if (half_y != PIX_W'(signed'(half_y[DATA_W-1:0]))) begin
            view_y_in = half_y[PIX_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            view_y_in = half_y[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         view_x_ff <= view_x_in;
         view_y_ff <= view_y_in;
      end
   end

   assign rsp_if.valid  = sb_ff[LAST].valid && sb_ff[LAST].point;
   assign rsp_if.status = sb_ff[LAST].status;
   assign rsp_if.view_x = view_x_ff;
   assign rsp_if.view_y = view_y_ff;

   // A point that is not visible always reports the origin.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != STATUS_VISIBLE) |->
         (rsp_if.view_x == '0 && rsp_if.view_y == '0))
      else $error("non-visible transaction carries a nonzero position");

   // The pipeline only holds back requests while a response waits.
   assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("request stalled with no pending response");

   // A stalled pipeline keeps its output position.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(view_x_ff) && $stable(view_y_ff)))
      else $error("output position changed during a stall");

   // A kind-0 transaction never reaches the response channel.
   assert property (@(posedge clock) disable iff (reset)
      (sb_ff[LAST].valid && !sb_ff[LAST].point) |-> !rsp_if.valid)
      else $error("coefficient write produced a response");

endmodule
